// ===== rtl/core/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
// Used by the front end, the job queue, the byte emitter and the top level.
package mbp_pkg;

   localparam int MAX_FIELD_BITS = 32;
   // Bit fields are limited by the 32-bit data value as well
   localparam int BIT_LIMIT = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
   localparam int MAX_BYTE_WRITE = 4;
   localparam int JOB_BYTES = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      OP_BITS  = 1'b0,
      OP_BYTES = 1'b1
   } op_type;

   // Up to five finished bytes, entry 0 goes out first
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage

// ===== rtl/core/mbp_front.sv =====
// Front end: accepts writes, holds the partial byte and turns each write into a job.
// Depends on mbp_pkg.
module mbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              queue_full,
   input  mbp_pkg::op_type   op,
   input  logic [31:0]       data_value,
   input  logic [5:0]        field_count,
   output logic              in_ready,
   output mbp_pkg::push_type push
);

   logic [7:0]  partial_ff, partial_in;
   logic [2:0]  pos_ff, pos_in;
   logic        accept;
   logic [5:0]  nbits;
   logic [5:0]  lshift;
   logic [31:0] field_left;
   logic [39:0] merged;
   logic [5:0]  total;
   logic [2:0]  nfull;
   logic [2:0]  nbytes;
   logic [7:0]  next_partial;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (field_count > 6'(mbp_pkg::BIT_LIMIT)) begin
         nbits = 6'(mbp_pkg::BIT_LIMIT);
      end else begin
         nbits = field_count;
      end
      // left-align the field, drops the unused high bits as well
      lshift     = 6'd32 - nbits;
      field_left = data_value << lshift;
      merged     = {partial_ff, 32'd0} | ({field_left, 8'd0} >> pos_ff);
      total      = {3'd0, pos_ff} + nbits;
      nfull      = total[5:3];
      case (nfull)
         3'd0:    next_partial = merged[39:32];
         3'd1:    next_partial = merged[31:24];
         3'd2:    next_partial = merged[23:16];
         3'd3:    next_partial = merged[15:8];
         3'd4:    next_partial = merged[7:0];
         default: next_partial = 8'd0;
      endcase
      if (field_count > 6'(mbp_pkg::MAX_BYTE_WRITE)) begin
         nbytes = 3'(mbp_pkg::MAX_BYTE_WRITE);
      end else begin
         nbytes = field_count[2:0];
      end
   end

   always_comb begin
      partial_in = partial_ff;
      pos_in     = pos_ff;
      push.valid = 1'b0;
      push.job   = '0;
      if (op == mbp_pkg::OP_BITS) begin
         push.job.bytes[0] = merged[39:32];
         push.job.bytes[1] = merged[31:24];
         push.job.bytes[2] = merged[23:16];
         push.job.bytes[3] = merged[15:8];
         push.job.count    = nfull;
         if (accept) begin
            partial_in = next_partial;
            pos_in     = total[2:0];
            push.valid = (nfull != 3'd0);
         end
      end else begin
         if (pos_ff != 3'd0) begin
            // flush the padded partial byte ahead of the data bytes
            push.job.bytes = {data_value, partial_ff};
            push.job.count = nbytes + 3'd1;
         end else begin
            push.job.bytes = {8'd0, data_value};
            push.job.count = nbytes;
         end
         if (accept && nbytes != 3'd0) begin
            partial_in = 8'd0;
            pos_in     = 3'd0;
            push.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 8'd0;
         pos_ff     <= 3'd0;
      end else begin
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

// ===== rtl/core/mbp_queue.sv =====
// Short job queue between the front end and the byte emitter.
// Depends on mbp_pkg.
module mbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  mbp_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output mbp_pkg::job_type  head
);

   mbp_pkg::job_type                slot_ff [mbp_pkg::QUEUE_DEPTH];
   logic [mbp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mbp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mbp_pkg::QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                            do_pop;

   assign full      = (fill_ff == (mbp_pkg::QUEUE_PTR_W+1)'(mbp_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push.valid && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/core/mbp_back.sv =====
// Byte emitter: walks the head job one byte per cycle into the output register while the output is not stalled.
// Depends on mbp_pkg.
module mbp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  mbp_pkg::job_type job,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       emit;
   logic       is_last;

   assign out_free = !valid_ff || out_ready;
   assign emit     = job_valid && out_free;
   assign is_last  = (idx_ff == job.count - 3'd1);
   assign pop      = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = job.bytes[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/core/msb_first_bit_packer_unit.sv =====
// MSB-first bit packer.
// Top level: front end, job queue and byte emitter. Depends on mbp_pkg.
//
// req_ carries writes. req_tuser selects the kind: a bit-field write appends
// the low field_count bits of the value, most significant first; a byte write
// with a nonzero count flushes any partial byte (zero padded) and then sends
// 1 to 4 value bytes, least significant first. rsp_ carries the packed stream
// one byte per transfer; rsp_tlast marks the last byte caused by a write. Bits
// still held in the partial byte are never sent on their own. The first byte
// of a write passes through the job queue and then the output register. Output
// runs at one byte per cycle while rsp_ is not stalled; a write makes 0 to 5
// bytes, and a write making no byte pushes no job. A write is taken every cycle
// while the four-entry job queue has room.
// A stalled rsp_ side holds its byte; the queue keeps taking writes until full.
// Reset empties the queue and the output register and clears the partial byte.
module msb_first_bit_packer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_value[31:0], field_count[37:32], zeros
   input  logic [0:0]  req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast
);

   mbp_pkg::push_type push;
   mbp_pkg::job_type  head;
   logic              full;
   logic              not_empty;
   logic              pop;

   mbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .queue_full  (full),
      .op          (mbp_pkg::op_type'(req_tuser[0])),
      .data_value  (req_tdata[31:0]),
      .field_count (req_tdata[37:32]),
      .in_ready    (req_tready),
      .push        (push)
   );

   mbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/core/mbp_checker.sv =====
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on msb_first_bit_packer_unit.
module mbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp byte changed while stalled");

   // nothing left over from before reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // empty queue takes writes straight after reset
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

endmodule

bind msb_first_bit_packer_unit mbp_checker u_mbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/msb_first_bit_packer_unit_tb.sv =====
// Self-checking testbench for msb_first_bit_packer_unit: random and directed writes in,
// packed byte stream out, compared against a behavioural packer in a scoreboard class.
// Depends on mbp_pkg and the unit's RTL only.
module msb_first_bit_packer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } stream_byte_type;

   // Behavioural packer plus queue of bytes still owed by the unit
   class byte_stream_scoreboard;
      stream_byte_type expected_bytes[$];
      logic [7:0]      pending_byte;
      int              bits_held;
      int              errors;

      function new();
         pending_byte = 8'h00;
         bits_held    = 0;
         errors       = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50)
            $display("mismatch at %0t ns: %s", $time, msg);
      endtask

      function void note_write(mbp_pkg::op_type op, logic [31:0] value, logic [5:0] count);
         logic [7:0]      made[$];
         stream_byte_type entry;
         int              n;
         if (op == mbp_pkg::OP_BITS) begin
            n = (count > mbp_pkg::BIT_LIMIT) ? mbp_pkg::BIT_LIMIT : int'(count);
            for (int i = n; i > 0; i--) begin
               if (value[i-1])
                  pending_byte[7 - bits_held] = 1'b1;
               bits_held++;
               if (bits_held == 8) begin
                  made.push_back(pending_byte);
                  pending_byte = 8'h00;
                  bits_held    = 0;
               end
            end
         end else begin
            n = (count > mbp_pkg::MAX_BYTE_WRITE) ? mbp_pkg::MAX_BYTE_WRITE : int'(count);
            // an empty byte write leaves the partial byte alone
            if (n > 0 && bits_held > 0) begin
               made.push_back(pending_byte);
               pending_byte = 8'h00;
               bits_held    = 0;
            end
            for (int j = 0; j < n; j++)
               made.push_back(value[8*j +: 8]);
         end
         foreach (made[k]) begin
            entry.out_byte    = made[k];
            entry.last_of_run = (k == made.size() - 1);
            expected_bytes.push_back(entry);
         end
      endfunction

      task check_byte(logic [7:0] got_byte, logic got_last);
         stream_byte_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h tlast %0b with nothing expected", got_byte, got_last));
            return;
         end
         want = expected_bytes.pop_front();
         if (got_byte !== want.out_byte)
            report($sformatf("byte %02h, expected %02h", got_byte, want.out_byte));
         if (got_last !== want.last_of_run)
            report($sformatf("tlast %0b, expected %0b on byte %02h", got_last,
                             want.last_of_run, want.out_byte));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // data_value[31:0], field_count[37:32], zeros
   logic [0:0]  req_tuser = '0;    // operation[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // out_byte[7:0]
   logic        rsp_tlast;

   byte_stream_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   msb_first_bit_packer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: long hold-off takes priority over random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Inputs noted before outputs are checked, in one process
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_write(mbp_pkg::op_type'(req_tuser[0]), req_tdata[31:0],
                          req_tdata[37:32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_byte(rsp_tdata, rsp_tlast);
      end
   end

   // Called just after a falling edge; returns just after a falling edge
   task send_write(mbp_pkg::op_type op, logic [31:0] value, logic [5:0] count);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, count, value};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task send_random_write();
      mbp_pkg::op_type op;
      logic [5:0]      count;
      logic [31:0]     value;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         op    = mbp_pkg::OP_BITS;
         count = 6'($urandom_range(0, 32));
      end else if (pick < 85) begin
         op    = mbp_pkg::OP_BYTES;
         count = 6'($urandom_range(1, 4));
      end else if (pick < 93) begin
         op    = mbp_pkg::OP_BITS;
         count = 6'($urandom_range(33, 63));
      end else begin
         op    = mbp_pkg::OP_BYTES;
         count = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(5, 63));
      end
      case ($urandom_range(0, 9))
         0:       value = 32'h0000_0000;
         1:       value = 32'hffff_ffff;
         default: value = $urandom;
      endcase
      send_write(op, value, count);
   endtask

   task wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   initial begin
      int waited;
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, saturation, empty writes, flushes, signed fields
      send_write(mbp_pkg::OP_BITS,  32'hffff_ffff, 6'd0);
      send_write(mbp_pkg::OP_BITS,  32'h0000_0001, 6'd1);
      send_write(mbp_pkg::OP_BYTES, 32'hffff_ffff, 6'd0);
      send_write(mbp_pkg::OP_BYTES, 32'h0000_00a5, 6'd1);
      send_write(mbp_pkg::OP_BITS,  32'hffff_ffff, 6'd32);
      send_write(mbp_pkg::OP_BITS,  32'h0000_0005, 6'd3);
      send_write(mbp_pkg::OP_BITS,  32'h0000_0000, 6'd32);
      send_write(mbp_pkg::OP_BITS,  32'h1234_5678, 6'd45);
      send_write(mbp_pkg::OP_BITS,  32'hffff_ffff, 6'd63);
      send_write(mbp_pkg::OP_BYTES, 32'hdead_beef, 6'd4);
      send_write(mbp_pkg::OP_BYTES, 32'h0102_0304, 6'd5);
      send_write(mbp_pkg::OP_BYTES, 32'hffff_ffff, 6'd63);
      send_write(mbp_pkg::OP_BITS,  32'h0000_005a, 6'd8);
      send_write(mbp_pkg::OP_BITS,  32'h0000_007f, 6'd7);
      send_write(mbp_pkg::OP_BITS,  32'h0000_0000, 6'd1);
      send_write(mbp_pkg::OP_BITS,  32'h0000_000a, 6'd4);
      send_write(mbp_pkg::OP_BYTES, 32'h1122_3344, 6'd63);
      send_write(mbp_pkg::OP_BITS,  32'hffff_fff1, 6'd5);
      send_write(mbp_pkg::OP_BYTES, 32'h0000_beef, 6'd2);
      send_write(mbp_pkg::OP_BYTES, 32'h00c0_ffee, 6'd3);
      send_write(mbp_pkg::OP_BITS,  32'h8000_0001, 6'd32);
      send_write(mbp_pkg::OP_BITS,  32'hffff_8000, 6'd16);
      send_write(mbp_pkg::OP_BYTES, 32'h0000_0000, 6'd4);

      send_idle_pct = 31;
      recv_idle_pct = 86;
      repeat (130) send_random_write();

      send_idle_pct = 86;
      recv_idle_pct = 31;
      repeat (130) send_random_write();

      // sender pauses until the stream is fully drained
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < 120; n++) begin
         // long receiver hold-off while writes keep coming: queue fills, req_ stalls
         if (n == 20)
            hold_left <= 64;
         send_random_write();
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (sb.pending() != 0)
         sb.report($sformatf("%0d bytes never arrived", sb.pending()));
      repeat (20) @(negedge clock);

      if (sb.errors == 0)
         $display("msb_first_bit_packer_unit_tb OK");
      else
         $display("msb_first_bit_packer_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout at %0t ns", $time);
      $display("msb_first_bit_packer_unit_tb NOT OK");
      $finish;
   end

endmodule
